### rtl/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

  localparam logic [7:0] TimeoutReset = 8'd250;
  localparam logic [7:0] MsbMask      = 8'h80;
  localparam logic [7:0] WaitMax      = 8'hff;
  localparam logic [3:0] BitsPerByte  = 4'd8;

  // command codes; idle doubles as the tick-only action
  typedef enum logic [3:0] {
    CMD_IDLE      = 4'd0,
    CMD_START     = 4'd1,
    CMD_STOP      = 4'd2,
    CMD_SEND      = 4'd3,
    CMD_WAIT      = 4'd4,
    CMD_READ_ACK  = 4'd5,
    CMD_READ_NACK = 4'd6,
    CMD_ACK       = 4'd7,
    CMD_NACK      = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_ack;
    logic       ignored;
  } out_item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] phase;
    logic [3:0] bit_count;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] wait_count;
    logic       scl;
    logic       sda;
    logic       nack;
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic ignored;
  } step_flags_t;

endpackage

### rtl/i2cms_if.sv
// valid/ready channels for items, results and the timeout register
interface i2cms_in_if import i2cms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_out_if import i2cms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/i2c_master_bit_sequencer.sv
// i2c master bit sequencer: one bus delay tick per item
//
// in_i carries one tick per beat: the action code, the byte to send and the
// sampled sda level. a start, stop, send, ack-wait, read or lone ack/nack
// command is taken only while idle; the step of the accepting tick is
// already applied. out_o returns exactly one result beat per tick: scl and
// sda levels (1 released, 0 driven low), busy, a done pulse, the receive
// shift register, the no-ack flag and an ignored flag for commands dropped
// while busy. cfg_i writes the ack timeout in ticks (reset 250); write it
// only while the block is idle.
// the result beat is registered at the accepting edge; a new tick is taken
// every cycle while out_o does not stall, since the whole step is one
// combinational pass from the state registers into the result register.
// when out_o stalls, the held result blocks in_i only once the result
// register is full; in_i stays ready while the result is being taken.
// reset releases both lines, empties the result register and sets idle.
module i2c_master_bit_sequencer import i2cms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cms_in_if.sink   in_i,
  i2cms_out_if.source out_o,
  i2cms_cfg_if.sink  cfg_i
);

  seq_state_t state_q, state_d;
  out_item_t  out_q, out_d;
  logic       out_valid_q;
  logic [7:0] timeout_q;
  logic       accept;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  i2cms_step u_step (
    .state_i       (state_q),
    .item_i        (in_i.data),
    .ack_timeout_i (timeout_q),
    .state_o       (state_d),
    .result_o      (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{cmd: CMD_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
      out_valid_q <= 1'b0;
      timeout_q   <= TimeoutReset;
    end else begin
      if (accept) state_q <= state_d;
      if (accept) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_i.valid) timeout_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done beat reports busy");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted tick left no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cmd == CMD_IDLE |-> state_q.phase == 3'd0 && state_q.bit_count == 4'd0)
    else $error("idle sequencer holds step counters");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("sequencer state moved without a tick");
`endif

endmodule

### rtl/i2cms_step.sv
// one tick of the command sequencer: next state and result fields
module i2cms_step import i2cms_pkg::*; (
  input  seq_state_t  state_i,
  input  in_item_t    item_i,
  input  logic [7:0]  ack_timeout_i,
  output seq_state_t  state_o,
  output out_item_t   result_o
);

  seq_state_t  s;
  step_flags_t flags;

  always_comb begin
    logic tail;
    logic tail_ack;
    logic run_done;
    s        = state_i;
    flags    = '0;
    tail     = 1'b0;
    tail_ack = 1'b0;
    run_done = 1'b0;

    if (state_i.cmd != CMD_IDLE) begin
      flags.ignored = (item_i.action != CMD_IDLE);
    end else if (item_i.action >= CMD_START && item_i.action <= CMD_NACK) begin
      s.cmd        = cmd_e'(item_i.action);
      s.phase      = '0;
      s.bit_count  = '0;
      s.wait_count = '0;
      if (s.cmd == CMD_SEND) s.tx_shift = item_i.write_data;
      if (s.cmd == CMD_READ_ACK || s.cmd == CMD_READ_NACK) s.rx_shift = '0;
      if (s.cmd == CMD_WAIT) s.nack = 1'b0;
    end

    case (s.cmd)
      CMD_START: begin
        case (s.phase)
          3'd0: begin s.scl = 1'b1; s.sda = 1'b1; s.phase = 3'd1; end
          3'd1: begin s.sda = 1'b0; s.phase = 3'd2; end
          default: begin s.scl = 1'b0; run_done = 1'b1; end
        endcase
      end
      CMD_STOP: begin
        case (s.phase)
          3'd0: begin s.sda = 1'b0; s.scl = 1'b0; s.phase = 3'd1; end
          3'd1: begin s.scl = 1'b1; s.phase = 3'd2; end
          default: begin s.sda = 1'b1; run_done = 1'b1; end
        endcase
      end
      CMD_SEND: begin
        if (s.bit_count >= BitsPerByte) begin
          s.scl    = 1'b0;
          s.sda    = 1'b1;
          run_done = 1'b1;
        end else if (s.phase == 3'd0) begin
          s.scl      = 1'b0;
          s.sda      = |(s.tx_shift & MsbMask);
          s.tx_shift = {s.tx_shift[6:0], 1'b0};
          s.phase    = 3'd1;
        end else begin
          s.scl       = 1'b1;
          s.phase     = 3'd0;
          s.bit_count = s.bit_count + 4'd1;
        end
      end
      CMD_WAIT: begin
        case (s.phase)
          3'd0: begin s.sda = 1'b1; s.phase = 3'd1; end
          3'd1: begin s.scl = 1'b1; s.phase = 3'd2; end
          3'd2: begin
            if (!item_i.sda_in) begin
              s.scl    = 1'b0;
              run_done = 1'b1;
            end else begin
              // saturating count of high samples
              if (s.wait_count != WaitMax) s.wait_count = s.wait_count + 8'd1;
              if (s.wait_count > ack_timeout_i) begin
                s.nack  = 1'b1;
                s.sda   = 1'b0;
                s.scl   = 1'b0;
                s.phase = 3'd3;
              end
            end
          end
          3'd3: begin s.scl = 1'b1; s.phase = 3'd4; end
          3'd4: begin s.sda = 1'b1; s.phase = 3'd5; end
          default: begin s.scl = 1'b0; run_done = 1'b1; end
        endcase
      end
      CMD_READ_ACK, CMD_READ_NACK: begin
        if (s.bit_count >= BitsPerByte) begin
          tail     = 1'b1;
          tail_ack = (s.cmd == CMD_READ_ACK);
        end else if (s.phase == 3'd0) begin
          s.scl   = 1'b1;
          s.phase = 3'd1;
        end else begin
          s.rx_shift  = {s.rx_shift[6:0], item_i.sda_in};
          s.scl       = 1'b0;
          s.phase     = 3'd0;
          s.bit_count = s.bit_count + 4'd1;
        end
      end
      CMD_ACK: begin
        tail     = 1'b1;
        tail_ack = 1'b1;
      end
      CMD_NACK: begin
        tail     = 1'b1;
        tail_ack = 1'b0;
      end
      default: begin
        run_done = 1'b0;
      end
    endcase

    // ack or nack bit after a read, or on its own
    if (tail) begin
      case (s.phase)
        3'd0: begin s.sda = !tail_ack; s.phase = 3'd1; end
        3'd1: begin s.scl = 1'b1; s.phase = 3'd2; end
        3'd2: begin
          s.scl = 1'b0;
          if (tail_ack) s.phase = 3'd3;
          else run_done = 1'b1;
        end
        default: begin s.sda = 1'b1; run_done = 1'b1; end
      endcase
    end

    if (run_done) begin
      s.cmd       = CMD_IDLE;
      s.phase     = '0;
      s.bit_count = '0;
    end
    flags.done = run_done;
  end

  always_comb begin
    result_o.scl_level = s.scl;
    result_o.sda_level = s.sda;
    result_o.busy_res  = (s.cmd != CMD_IDLE);
    result_o.done_res  = flags.done;
    result_o.read_byte = s.rx_shift;
    result_o.no_ack    = s.nack;
    result_o.ignored   = flags.ignored;
  end

  assign state_o = s;

endmodule
